[rtl/core/lmafg_pkg.sv]
// Package for the LED matrix animation frame generator.
// Types, sprite ROMs and constants; no dependencies.
`timescale 1ns / 1ps
package lmafg_pkg;

  localparam int unsigned COLUMNS = 32;
  localparam int unsigned COL_W = $clog2(COLUMNS);

  typedef enum logic [1:0] {
    OP_HEARTBEAT = 2'd0,
    OP_HEARTS    = 2'd1,
    OP_SPARKLE   = 2'd2,
    OP_ARROW     = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [4:0] column_index;
    logic [7:0] column_bits;
    logic       last_column;
    logic [6:0] frame_interval_ms;
  } out_item_t;

  // Per-frame values computed once per input item.
  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] t1300;
    logic [11:0] t2600;
    logic [5:0]  d39;
    logic [31:0] slot;
  } frame_t;

  function automatic logic [7:0] big_heart(input logic [3:0] k);
    case (k)
      4'd0, 4'd8: big_heart = 8'h0E;
      4'd1, 4'd7: big_heart = 8'h1F;
      4'd2, 4'd6: big_heart = 8'h3F;
      4'd3, 4'd5: big_heart = 8'h7E;
      4'd4:       big_heart = 8'hFE;
      default:    big_heart = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] mid_heart(input logic [3:0] k);
    case (k)
      4'd0, 4'd6: mid_heart = 8'h0C;
      4'd1, 4'd5: mid_heart = 8'h1E;
      4'd2, 4'd4: mid_heart = 8'h3E;
      4'd3:       mid_heart = 8'h7C;
      default:    mid_heart = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] small_heart(input logic [3:0] k);
    case (k)
      4'd0, 4'd4: small_heart = 8'h18;
      4'd1, 4'd3: small_heart = 8'h3C;
      4'd2:       small_heart = 8'h78;
      default:    small_heart = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] arrow_spr(input logic [3:0] k);
    case (k)
      4'd0, 4'd1, 4'd2, 4'd3: arrow_spr = 8'h10;
      4'd4:    arrow_spr = 8'h54;
      4'd5:    arrow_spr = 8'h38;
      default: arrow_spr = 8'h00;
    endcase
  endfunction

endpackage

[rtl/core/led_matrix_animation_frame_generator_unit.sv]
// Top level of the LED matrix animation frame generator.
// Depends on lmafg_pkg, lmafg_frame_prep and lmafg_column_pipe.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid_i/in_stall_o/in_item_i carries an animation
//   selector and elapsed time in ms. Each accepted transfer produces
//   COLUMNS result transfers on out_valid_o/out_stall_i/out_item_o, one per
//   column left to right, the last one flagged by last_column.
//   The column sequencer holds one input item while it issues that item's
//   COLUMNS columns, one result per cycle while the receiver does not stall.
//   The next frame enters the sequencer at the same edge that issues the
//   previous frame's last column, so frames follow back to back.
//   The path from input transfer to out_item_o has eight register stages:
//   three of time reduction (reciprocal multiply, correction, final
//   reductions), the column sequencer, and four column stages (sprites and
//   seeds, two hash multiplies, threshold and arrow placement into the
//   output register).
//   When the receiver stalls, the whole pipeline holds; nothing is lost
//   or repeated. in_stall_o is combinational from out_stall_i and the
//   sequencer state; it stays high while a finished frame waits.
//   Reset clears all valid bits and the column counter; no clearing pass.
module led_matrix_animation_frame_generator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lmafg_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lmafg_pkg::out_item_t out_item_o
);

  localparam int unsigned CW = lmafg_pkg::COL_W;

  logic adv;
  logic pv;
  lmafg_pkg::frame_t pf;
  logic              hold_q;  // frame latched for column sweep
  lmafg_pkg::frame_t hf_q;
  logic [CW-1:0]     col_q;
  logic              take;
  logic              cvalid;

  assign adv = !(out_valid_o && out_stall_i);

  // The prep pipe only advances when its output can be taken.
  logic prep_adv;
  assign take     = pv && (!hold_q || (col_q == CW'(lmafg_pkg::COLUMNS - 1)));
  assign prep_adv = adv && (!pv || take);
  assign in_stall_o = !prep_adv;

  lmafg_frame_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (prep_adv),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (pv),
    .frame_o (pf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      col_q  <= '0;
    end else if (adv) begin
      if (hold_q && col_q != CW'(lmafg_pkg::COLUMNS - 1)) begin
        col_q <= col_q + CW'(1);
      end else if (take) begin
        hold_q <= 1'b1;
        col_q  <= '0;
      end else begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && take && !(hold_q && col_q != CW'(lmafg_pkg::COLUMNS - 1))) hf_q <= pf;
  end

  assign cvalid = hold_q;

  lmafg_column_pipe u_cols (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (cvalid),
    .frame_i (hf_q),
    .col_i   (col_q),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

endmodule

[rtl/core/lmafg_frame_prep.sv]
// Per-frame preparation: time reductions and sparkle slot, three stages.
// Depends on lmafg_pkg.
`timescale 1ns / 1ps
module lmafg_frame_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  lmafg_pkg::in_item_t item_i,
  output logic                valid_o,
  output lmafg_pkg::frame_t   frame_o
);

  // Stage 1: quotients by reciprocal multiply (floor(x*M) >> s), 32x32.
  logic [1:0]  op1_q;
  logic [31:0] ms1_q;
  logic [63:0] q1300p_q, q2600p_q, q2145p_q, q110p_q;
  logic        v1_q, v2_q, v3_q;
  // Stage 2: corrected quotients and remainders.
  logic [1:0]  op2_q;
  logic [31:0] ms2_q, q110_q, q1300_q, q2600_q;
  logic [11:0] t2145_q;
  // Stage 3
  lmafg_pkg::frame_t fr_q;

  localparam logic [31:0] M1300 = 32'd3303820;  // ~2^32/1300
  localparam logic [31:0] M2600 = 32'd1651910;
  localparam logic [31:0] M2145 = 32'd2002315;  // 2145 = 55*39
  localparam logic [31:0] M110  = 32'd39045157;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op1_q    <= item_i.opcode;
      ms1_q    <= item_i.elapsed_ms;
      q1300p_q <= 64'(item_i.elapsed_ms) * 64'(M1300);
      q2600p_q <= 64'(item_i.elapsed_ms) * 64'(M2600);
      q2145p_q <= 64'(item_i.elapsed_ms) * 64'(M2145);
      q110p_q  <= 64'(item_i.elapsed_ms) * 64'(M110);
    end
  end

  // Estimates are low by at most one; fix with one compare each.
  logic [31:0] e1300, e2600, e2145, e110;
  logic [31:0] r1300, r2600, r2145, r110;
  always_comb begin
    e1300 = q1300p_q[63:32];
    e2600 = q2600p_q[63:32];
    e2145 = q2145p_q[63:32];
    e110  = q110p_q[63:32];
    r1300 = ms1_q - 32'(e1300 * 32'd1300);
    r2600 = ms1_q - 32'(e2600 * 32'd2600);
    r2145 = ms1_q - 32'(e2145 * 32'd2145);
    r110  = ms1_q - 32'(e110 * 32'd110);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op2_q   <= op1_q;
      ms2_q   <= ms1_q;
      q1300_q <= (r1300 >= 32'd1300) ? e1300 + 32'd1 : e1300;
      q2600_q <= (r2600 >= 32'd2600) ? e2600 + 32'd1 : e2600;
      t2145_q <= (r2145 >= 32'd2145) ? 12'(r2145 - 32'd2145) : 12'(r2145);
      q110_q  <= (r110 >= 32'd110) ? e110 + 32'd1 : e110;
    end
  end

  // (ms/55) mod 39 = (ms mod 2145)/55; x*1192 >> 16 is exact below 2145.
  logic [23:0] p55;
  always_comb begin
    p55 = 24'(t2145_q) * 24'd1192;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fr_q.op    <= op2_q;
      fr_q.t1300 <= 11'(ms2_q - 32'(q1300_q * 32'd1300));
      fr_q.t2600 <= 12'(ms2_q - 32'(q2600_q * 32'd2600));
      fr_q.d39   <= p55[21:16];
      fr_q.slot  <= q110_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign frame_o = fr_q;

endmodule

[rtl/core/lmafg_column_pipe.sv]
// Column render pipeline: one column per cycle unless stalled, sparkle hash over stages.
// Depends on lmafg_pkg.
`timescale 1ns / 1ps
module lmafg_column_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  lmafg_pkg::frame_t                   frame_i,
  input  logic [lmafg_pkg::COL_W-1:0]         col_i,
  output logic                                valid_o,
  output lmafg_pkg::out_item_t                item_o
);

  localparam int unsigned CW = lmafg_pkg::COL_W;
  localparam int signed NC = lmafg_pkg::COLUMNS;

  // Stage A: sprite columns and hash seeds; arrow time.
  logic              va_q;
  logic [1:0]        opa_q;
  logic [CW-1:0]     cola_q;
  logic [7:0]        spra_q;
  logic [31:0]       seeda_q [16];
  logic [11:0]       ta_q;

  function automatic logic [7:0] put(input int signed col, input int signed left,
                                      input int signed w, input logic [2:0] which);
    int signed k;
    logic [7:0] r;
    begin
      k = col - left;
      r = 8'h00;
      if (k >= 0 && k < w) begin
        case (which)
          3'd0:    r = lmafg_pkg::big_heart(4'(k));
          3'd1:    r = lmafg_pkg::mid_heart(4'(k));
          default: r = lmafg_pkg::small_heart(4'(k));
        endcase
      end
      put = r;
    end
  endfunction

  logic [7:0]  spr_d;
  int signed   c_s, d_s;
  logic [31:0] sa, sb;
  always_comb begin
    c_s = int'(col_i);
    d_s = int'(frame_i.d39);
    spr_d = 8'h00;
    sa = frame_i.slot * 32'd7919;
    sb = (frame_i.slot - 32'd1) * 32'd7919;
    case (frame_i.op)
      lmafg_pkg::OP_HEARTBEAT: begin
        if (frame_i.t1300 < 11'd130 || (frame_i.t1300 >= 11'd260 && frame_i.t1300 < 11'd400))
          spr_d = put(c_s, (NC - 9) / 2, 9, 3'd0);
        else if (frame_i.t1300 < 11'd520)
          spr_d = put(c_s, (NC - 7) / 2, 7, 3'd1);
        else
          spr_d = put(c_s, (NC - 5) / 2, 5, 3'd2);
      end
      lmafg_pkg::OP_HEARTS: begin
        for (int i = -1; i < 4; i++)
          spr_d = spr_d | put(c_s, NC - d_s + i * 13, 7, 3'd1);
      end
      lmafg_pkg::OP_ARROW: begin
        if (frame_i.t2600 > 12'd700 && frame_i.t2600 < 12'd1050)
          spr_d = put(c_s, (NC - 9) / 2, 9, 3'd0);
        else
          spr_d = put(c_s, (NC - 7) / 2, 7, 3'd1);
      end
      default: spr_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      opa_q  <= frame_i.op;
      cola_q <= col_i;
      spra_q <= spr_d;
      ta_q   <= frame_i.t2600;
      for (int r = 0; r < 8; r++) begin
        seeda_q[2*r]   <= 32'(col_i) * 32'd911 + 32'(r) * 32'd3571 + sa;
        seeda_q[2*r+1] <= 32'(col_i) * 32'd911 + 32'(r) * 32'd3571 + sb;
      end
    end
  end

  // Stage B: first hash multiply; arrow product for the x position.
  logic [31:0] hb_q [16];
  logic [1:0]  opb_q;
  logic [CW-1:0] colb_q;
  logic [7:0]  sprb_q;
  logic [11:0] tb_q;
  logic [31:0] ax_q;  // t*(COLUMNS+6)
  logic        vb_q, vc_q, vd_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      opb_q  <= opa_q;
      colb_q <= cola_q;
      sprb_q <= spra_q;
      tb_q   <= ta_q;
      ax_q   <= 32'(ta_q) * 32'(NC + 6);
      for (int j = 0; j < 16; j++)
        hb_q[j] <= (seeda_q[j] ^ (seeda_q[j] >> 16)) * 32'h7FEB352D;
    end
  end

  // Stage C: second hash multiply; arrow divide by 1400 via reciprocal.
  logic [31:0] hc_q [16];
  logic [1:0]  opc_q;
  logic [CW-1:0] colc_q;
  logic [7:0]  sprc_q;
  logic        arc_q;
  logic [31:0] axc_q;
  logic [63:0] axp_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      opc_q  <= opb_q;
      colc_q <= colb_q;
      sprc_q <= sprb_q;
      arc_q  <= (tb_q < 12'd1400);
      axc_q  <= ax_q;
      axp_q  <= 64'(ax_q) * 64'd3067833;  // ~2^32/1400
      for (int j = 0; j < 16; j++)
        hc_q[j] <= (hb_q[j] ^ (hb_q[j] >> 15)) * 32'h846CA68B;
    end
  end

  // Stage D: hash threshold, arrow column.
  logic [31:0] eq, rq, xq;
  logic [7:0]  spk, arw;
  int signed   xs;
  logic [7:0]  hf [16];
  always_comb begin
    eq = axp_q[63:32];
    rq = axc_q - 32'(eq * 32'd1400);
    xq = (rq >= 32'd1400) ? eq + 32'd1 : eq;
    xs = int'(xq) - 6;
    arw = 8'h00;
    if (arc_q && int'(colc_q) - xs >= 0 && int'(colc_q) - xs < 6)
      arw = lmafg_pkg::arrow_spr(4'(int'(colc_q) - xs));
    spk = 8'h00;
    for (int j = 0; j < 16; j++)
      hf[j] = 8'(hc_q[j] ^ (hc_q[j] >> 16));
    for (int r = 0; r < 8; r++)
      spk[r] = (hf[2*r] < 8'd14) || (hf[2*r+1] < 8'd8);
  end

  lmafg_pkg::out_item_t od_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      od_q.column_index <= 5'(colc_q);
      od_q.last_column  <= (colc_q == CW'(NC - 1));
      case (opc_q)
        lmafg_pkg::OP_HEARTS: begin
          od_q.column_bits       <= sprc_q;
          od_q.frame_interval_ms <= 7'd55;
        end
        lmafg_pkg::OP_SPARKLE: begin
          od_q.column_bits       <= spk;
          od_q.frame_interval_ms <= 7'd110;
        end
        lmafg_pkg::OP_ARROW: begin
          od_q.column_bits       <= sprc_q | arw;
          od_q.frame_interval_ms <= 7'd40;
        end
        default: begin
          od_q.column_bits       <= sprc_q;
          od_q.frame_interval_ms <= 7'd40;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  assign valid_o = vd_q;
  assign item_o  = od_q;

endmodule

[rtl/core/lmafg_checker.sv]
// Port-level checker for the frame generator top level, with its bind.
// Depends on lmafg_pkg.
`timescale 1ns / 1ps
module lmafg_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input lmafg_pkg::out_item_t out_item_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output changed");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.last_column ==
      (out_item_o.column_index == 5'(lmafg_pkg::COLUMNS - 1)))
    else $error("last_column mismatch");

  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_column ##1 out_valid_o
      |-> out_item_o.column_index == $past(out_item_o.column_index) + 5'd1)
    else $error("column order broken");

  a_per: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.frame_interval_ms == 7'd40 ||
      out_item_o.frame_interval_ms == 7'd55 || out_item_o.frame_interval_ms == 7'd110)
    else $error("bad frame interval");

endmodule

bind led_matrix_animation_frame_generator_unit lmafg_checker u_lmafg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[test/tb_top.sv]
// Testbench for the LED matrix animation frame generator.
// Depends on lmafg_pkg and led_matrix_animation_frame_generator_unit.
`timescale 1ns / 1ps
module tb_top;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  lmafg_pkg::in_item_t  in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b1;
  lmafg_pkg::out_item_t out_item_o;

  bit        stim_done = 1'b0;
  bit        hold_req = 1'b0;

  led_matrix_animation_frame_generator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  class frame_scoreboard;
    lmafg_pkg::out_item_t columns_q[$];
    int        errors;
    byte       fb[lmafg_pkg::COLUMNS];

    function void put(input byte spr[], input int left);
      int k;
      int c;
      for (k = 0; k < spr.size(); k++) begin
        c = left + k;
        if (c >= 0 && c < lmafg_pkg::COLUMNS) fb[c] |= spr[k];
      end
    endfunction

    function bit [31:0] scramble(input bit [31:0] v);
      v ^= v >> 16;
      v *= 32'h7FEB352D;
      v ^= v >> 15;
      v *= 32'h846CA68B;
      v ^= v >> 16;
      return v;
    endfunction

    function void note_frame(input lmafg_pkg::in_item_t it);
      byte big[]   = '{8'h0E, 8'h1F, 8'h3F, 8'h7E, 8'hFE, 8'h7E, 8'h3F, 8'h1F, 8'h0E};
      byte mid[]   = '{8'h0C, 8'h1E, 8'h3E, 8'h7C, 8'h3E, 8'h1E, 8'h0C};
      byte small_h[] = '{8'h18, 8'h3C, 8'h78, 8'h3C, 8'h18};
      byte arr[]   = '{8'h10, 8'h10, 8'h10, 8'h10, 8'h54, 8'h38};
      bit [31:0] ms;
      bit [31:0] t;
      bit [31:0] slot;
      bit [31:0] base;
      int        d;
      int        c;
      int        r;
      bit [6:0]  period;
      lmafg_pkg::out_item_t o;
      ms = it.elapsed_ms;
      for (c = 0; c < lmafg_pkg::COLUMNS; c++) fb[c] = 0;
      case (lmafg_pkg::op_e'(it.opcode))
        lmafg_pkg::OP_HEARTBEAT: begin
          period = 7'd40;
          t = ms % 1300;
          if (t < 130 || (t >= 260 && t < 400)) put(big, (lmafg_pkg::COLUMNS - 9) / 2);
          else if (t < 520) put(mid, (lmafg_pkg::COLUMNS - 7) / 2);
          else put(small_h, (lmafg_pkg::COLUMNS - 5) / 2);
        end
        lmafg_pkg::OP_HEARTS: begin
          period = 7'd55;
          d = (ms / 55) % 39;
          for (int i = -1; i < 4; i++) put(mid, lmafg_pkg::COLUMNS - d + i * 13);
        end
        lmafg_pkg::OP_SPARKLE: begin
          period = 7'd110;
          slot = ms / 110;
          for (c = 0; c < lmafg_pkg::COLUMNS; c++) begin
            for (r = 0; r < 8; r++) begin
              base = c * 911 + r * 3571;
              if ((scramble(base + slot * 7919) & 8'hFF) < 14 ||
                  (scramble(base + (slot - 1) * 7919) & 8'hFF) < 8)
                fb[c] |= 8'(1 << r);
            end
          end
        end
        default: begin
          period = 7'd40;
          t = ms % 2600;
          if (t > 700 && t < 1050) put(big, (lmafg_pkg::COLUMNS - 9) / 2);
          else put(mid, (lmafg_pkg::COLUMNS - 7) / 2);
          if (t < 1400) put(arr, -6 + int'((t * (lmafg_pkg::COLUMNS + 6)) / 1400));
        end
      endcase
      for (c = 0; c < lmafg_pkg::COLUMNS; c++) begin
        o.column_index = 5'(c);
        o.column_bits = fb[c];
        o.last_column = (c == lmafg_pkg::COLUMNS - 1);
        o.frame_interval_ms = period;
        columns_q.push_back(o);
      end
    endfunction

    function void check_column(input lmafg_pkg::out_item_t got);
      lmafg_pkg::out_item_t exp_c;
      if (columns_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected column %p", $time, got);
        return;
      end
      exp_c = columns_q.pop_front();
      if (got.column_index !== exp_c.column_index) begin
        errors++;
        $display("%0t: column_index exp %0d got %0d", $time, exp_c.column_index,
                 got.column_index);
      end
      if (got.column_bits !== exp_c.column_bits) begin
        errors++;
        $display("%0t: column_bits col %0d exp %h got %h", $time, exp_c.column_index,
                 exp_c.column_bits, got.column_bits);
      end
      if (got.last_column !== exp_c.last_column) begin
        errors++;
        $display("%0t: last_column exp %b got %b", $time, exp_c.last_column,
                 got.last_column);
      end
      if (got.frame_interval_ms !== exp_c.frame_interval_ms) begin
        errors++;
        $display("%0t: frame_interval_ms exp %0d got %0d", $time,
                 exp_c.frame_interval_ms, got.frame_interval_ms);
      end
    endfunction
  endclass

  frame_scoreboard sb = new();

  // Monitor: sample transfers at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_frame(in_item_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_column(out_item_o);
  end

  // Valid stays up between items sent with no gap.
  task automatic send_frame(input lmafg_pkg::op_e op, input logic [31:0] ms);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{opcode: op, elapsed_ms: ms};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random();
    logic [31:0] ms;
    case ($urandom_range(0, 3))
      0: ms = $urandom();
      1: ms = $urandom_range(0, 3000);
      2: ms = 32'($urandom_range(0, 400)) * 110 + $urandom_range(0, 109);
      default: ms = ~32'($urandom_range(0, 3000));
    endcase
    send_frame(lmafg_pkg::op_e'($urandom_range(0, 3)), ms);
  endtask

  // Receiver: random stalls, with one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end
      n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      out_stall_i <= (n != 0);
      if (n != 0) repeat (n - 1) @(posedge clk_i);
    end
  end

  initial begin
    logic [31:0] edge_ms[] = '{32'd0, 32'd129, 32'd130, 32'd259, 32'd260, 32'd399,
                               32'd400, 32'd519, 32'd520, 32'd700, 32'd701, 32'd1049,
                               32'd1050, 32'd1399, 32'd109, 32'd110, 32'hFFFF_FFFF};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: boundaries of each animation, slot zero, wrap.
    for (int i = 0; i < edge_ms.size(); i++)
      send_frame(lmafg_pkg::op_e'(i % 4), edge_ms[i]);
    send_frame(lmafg_pkg::OP_SPARKLE, 32'd0);
    send_frame(lmafg_pkg::OP_ARROW, 32'd1399);
    send_frame(lmafg_pkg::OP_ARROW, 32'd1400);
    send_frame(lmafg_pkg::OP_HEARTS, 32'd2144);
    send_frame(lmafg_pkg::OP_HEARTBEAT, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_random();
    for (int i = 0; i < 390; i++) send_random();
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (sb.columns_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end
endmodule
